>>> src/lc3_pkg.sv
// Shared types, command and opcode codes for the LC-3 instruction step block.
// No dependencies; imported by every module of the block.
`default_nettype none
package lc3_pkg;

  localparam int ADDR_BITS = 16;

  localparam logic [1:0] CMD_STEP = 2'd0;
  localparam logic [1:0] CMD_MEM  = 2'd1;
  localparam logic [1:0] CMD_REG  = 2'd2;

  localparam logic [3:0] OP_BR   = 4'd0;
  localparam logic [3:0] OP_ADD  = 4'd1;
  localparam logic [3:0] OP_LD   = 4'd2;
  localparam logic [3:0] OP_ST   = 4'd3;
  localparam logic [3:0] OP_JSR  = 4'd4;
  localparam logic [3:0] OP_AND  = 4'd5;
  localparam logic [3:0] OP_LDR  = 4'd6;
  localparam logic [3:0] OP_STR  = 4'd7;
  localparam logic [3:0] OP_NOT  = 4'd9;
  localparam logic [3:0] OP_LDI  = 4'd10;
  localparam logic [3:0] OP_STI  = 4'd11;
  localparam logic [3:0] OP_JMP  = 4'd12;
  localparam logic [3:0] OP_LEA  = 4'd14;
  localparam logic [3:0] OP_TRAP = 4'd15;

  localparam logic [7:0] TRAP_HALT = 8'h25;
  localparam logic [7:0] TRAP_IN   = 8'h20;

  localparam logic [2:0] CC_NEG  = 3'd4;
  localparam logic [2:0] CC_ZERO = 3'd2;
  localparam logic [2:0] CC_POS  = 3'd1;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [15:0] load_address;
    logic [15:0] load_data;
    logic [15:0] console_value;
  } in_item_t;

  typedef struct packed {
    logic [15:0] next_pc;
    logic [2:0]  cond_code;
    logic [15:0] executed_word;
    logic        halted;
  } out_item_t;

  // Queue entry: the item plus its class, settled at the front.
  typedef struct packed {
    in_item_t item;
    logic     is_step;
  } q_item_t;

  function automatic logic [2:0] cc_of(input logic [15:0] v);
    if (v == 16'd0) begin
      return CC_ZERO;
    end else if (v[15]) begin
      return CC_NEG;
    end else begin
      return CC_POS;
    end
  endfunction

endpackage
`default_nettype wire

>>> src/lc3_front.sv
// Front end: accepts items, classifies them and holds them in a two-entry queue.
// Depends on lc3_pkg.
`default_nettype none
module lc3_front
  import lc3_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire in_item_t in_data,
  output logic          q_valid,
  output q_item_t       q_data,
  input  wire logic     q_pop
);

  q_item_t    mem_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] count_r;
  logic       push;

  assign in_ready = (count_r != 2'd2);
  assign push     = in_valid && in_ready;
  assign q_valid  = (count_r != 2'd0);
  assign q_data   = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= '{item: in_data, is_step: (in_data.cmd == CMD_STEP)};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (q_pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      count_r <= count_r + 2'(push) - 2'(q_pop);
    end
  end

endmodule
`default_nettype wire

>>> src/lc3_back.sv
// Back end: sequencer that executes queued items against the register file,
// PC, condition code and the word memory; drives the result register. Uses lc3_pkg.
`default_nettype none
module lc3_back
  import lc3_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic [15:0] start_address,
  input  wire logic        start_valid,
  input  wire logic        q_valid,
  input  wire q_item_t     q_data,
  output logic             q_pop,
  output logic             out_valid,
  input  wire logic        out_ready,
  output out_item_t        out_data
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_WORD = 2'd1;
  localparam logic [1:0] S_MEM1 = 2'd2;
  localparam logic [1:0] S_MEM2 = 2'd3;

  logic [15:0] mem [2**ADDR_BITS];
  logic [15:0] mem_q;

  logic [15:0] rf_r [8];
  logic [15:0] pc_r;
  logic [2:0]  cc_r;
  logic [1:0]  state_r, state_nxt;
  logic [15:0] ir_r;
  logic [15:0] console_r;
  logic        out_valid_r;
  out_item_t   out_data_r;

  logic [15:0] ir;
  logic [3:0]  op;
  logic [2:0]  dr, sr1;
  logic [15:0] off9, off6, off11, opb, pc_off9, sr1_val, base_off6;
  logic        out_free;

  logic                 mem_we, mem_re;
  logic [ADDR_BITS-1:0] mem_addr;
  logic [15:0]          mem_wd;
  logic                 rf_we;
  logic [2:0]           rf_wa;
  logic [15:0]          rf_wd;
  logic                 cc_we;
  logic [15:0]          pc_nxt;
  logic                 out_load;
  logic                 ir_load;
  logic                 console_load;

  assign ir      = (state_r == S_WORD) ? mem_q : ir_r;
  assign op      = ir[15:12];
  assign dr      = ir[11:9];
  assign sr1     = ir[8:6];
  assign sr1_val = rf_r[sr1];
  assign off9    = {{7{ir[8]}}, ir[8:0]};
  assign off6    = {{10{ir[5]}}, ir[5:0]};
  assign off11   = {{5{ir[10]}}, ir[10:0]};
  assign opb     = ir[5] ? {{11{ir[4]}}, ir[4:0]} : rf_r[ir[2:0]];
  assign pc_off9 = pc_r + off9;
  assign base_off6 = sr1_val + off6;
  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt    = state_r;
    q_pop        = 1'b0;
    mem_we       = 1'b0;
    mem_re       = 1'b0;
    mem_addr     = pc_r[ADDR_BITS-1:0];
    mem_wd       = rf_r[dr];
    rf_we        = 1'b0;
    rf_wa        = dr;
    rf_wd        = mem_q;
    cc_we        = 1'b0;
    pc_nxt       = pc_r;
    out_load     = 1'b0;
    ir_load      = 1'b0;
    console_load = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (q_valid) begin
          if (q_data.is_step) begin
            mem_re       = 1'b1;
            pc_nxt       = pc_r + 16'd1;
            q_pop        = 1'b1;
            console_load = 1'b1;
            state_nxt    = S_WORD;
          end else if (out_free) begin
            q_pop    = 1'b1;
            out_load = 1'b1;
            mem_addr = q_data.item.load_address[ADDR_BITS-1:0];
            mem_wd   = q_data.item.load_data;
            rf_wa    = q_data.item.load_address[2:0];
            rf_wd    = q_data.item.load_data;
            mem_we   = (q_data.item.cmd == CMD_MEM);
            rf_we    = (q_data.item.cmd == CMD_REG);
          end
        end
      end
      S_WORD: begin
        ir_load = 1'b1;
        case (op)
          OP_LD, OP_LDI, OP_STI: begin
            mem_re    = 1'b1;
            mem_addr  = pc_off9[ADDR_BITS-1:0];
            state_nxt = S_MEM1;
          end
          OP_LDR: begin
            mem_re    = 1'b1;
            mem_addr  = base_off6[ADDR_BITS-1:0];
            state_nxt = S_MEM1;
          end
          default: begin
            if (out_free) begin
              out_load  = 1'b1;
              state_nxt = S_IDLE;
              case (op)
                OP_BR: begin
                  if ((dr & cc_r) != 3'd0) begin
                    pc_nxt = pc_off9;
                  end
                end
                OP_ADD: begin
                  rf_we = 1'b1;
                  rf_wd = sr1_val + opb;
                  cc_we = 1'b1;
                end
                OP_AND: begin
                  rf_we = 1'b1;
                  rf_wd = sr1_val & opb;
                  cc_we = 1'b1;
                end
                OP_NOT: begin
                  rf_we = 1'b1;
                  rf_wd = ~sr1_val;
                  cc_we = 1'b1;
                end
                OP_ST: begin
                  mem_we   = 1'b1;
                  mem_addr = pc_off9[ADDR_BITS-1:0];
                end
                OP_STR: begin
                  mem_we   = 1'b1;
                  mem_addr = base_off6[ADDR_BITS-1:0];
                end
                OP_JSR: begin
                  // read the target before R7 takes the return address
                  rf_we  = 1'b1;
                  rf_wa  = 3'd7;
                  rf_wd  = pc_r;
                  pc_nxt = ir[11] ? (pc_r + off11) : sr1_val;
                end
                OP_JMP: begin
                  pc_nxt = sr1_val;
                end
                OP_LEA: begin
                  rf_we = 1'b1;
                  rf_wd = pc_off9;
                end
                OP_TRAP: begin
                  if (ir[7:0] == TRAP_HALT) begin
                    pc_nxt = 16'd0;
                  end else if (ir[7:0] == TRAP_IN) begin
                    rf_we = 1'b1;
                    rf_wa = 3'd0;
                    rf_wd = console_r;
                  end
                end
                default: begin
                end
              endcase
            end
          end
        endcase
      end
      S_MEM1: begin
        if (op == OP_LDI) begin
          mem_re    = 1'b1;
          mem_addr  = mem_q[ADDR_BITS-1:0];
          state_nxt = S_MEM2;
        end else if (out_free) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
          if (op == OP_STI) begin
            mem_we   = 1'b1;
            mem_addr = mem_q[ADDR_BITS-1:0];
          end else begin
            rf_we = 1'b1;
            cc_we = 1'b1;
          end
        end
      end
      S_MEM2: begin
        if (out_free) begin
          out_load  = 1'b1;
          rf_we     = 1'b1;
          cc_we     = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // single-port word memory, registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wd;
    end
    if (mem_re) begin
      mem_q <= mem[mem_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (ir_load) begin
      ir_r <= mem_q;
    end
    if (console_load) begin
      console_r <= q_data.item.console_value;
    end
    if (out_load) begin
      out_data_r.next_pc       <= pc_nxt;
      out_data_r.cond_code     <= cc_we ? cc_of(rf_wd) : cc_r;
      out_data_r.executed_word <= (state_r == S_IDLE) ? 16'd0 : ir;
      out_data_r.halted        <= (state_r != S_IDLE) && (ir == 16'd0);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      pc_r        <= start_valid ? start_address : 16'd0;
      cc_r        <= 3'd0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < 8; i++) begin
        rf_r[i] <= 16'd0;
      end
    end else begin
      state_r <= state_nxt;
      pc_r    <= pc_nxt;
      if (cc_we) begin
        cc_r <= cc_of(rf_wd);
      end
      if (rf_we) begin
        rf_r[rf_wa] <= rf_wd;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
`default_nettype wire

>>> src/lc3_instruction_step_top.sv
// LC-3 instruction step block: one result per command. A front queue of two
// items decouples input acceptance from the executing back end, and the result
// sits in an output register so new items are taken while a result waits. Memory
// and register writes complete without a fetch. A step fetches, then executes; LD,
// LDR and STI read memory between and LDI reads twice, the word memory having one
// port. start_address is stored when written, but reset clears its valid flag, so
// the PC always leaves reset at zero. Memory contents are undefined until written.
// Depends on lc3_pkg, lc3_front and lc3_back.
`default_nettype none
module lc3_instruction_step_top
  import lc3_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [15:0] cfg_data,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire in_item_t    in_data,
  output logic             out_valid,
  input  wire logic        out_ready,
  output out_item_t        out_data
);

  logic [15:0] start_r;
  logic        start_valid_r;
  logic        q_valid, q_pop;
  q_item_t     q_data;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (cfg_valid) begin
      start_r <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_valid_r <= 1'b0;
    end else if (cfg_valid) begin
      start_valid_r <= 1'b1;
    end
  end

  lc3_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .q_valid  (q_valid),
    .q_data   (q_data),
    .q_pop    (q_pop)
  );

  // reset gates off the stored start address, so the PC is cleared to zero
  lc3_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .start_address (start_r),
    .start_valid   (start_valid_r && rst_n),
    .q_valid       (q_valid),
    .q_data        (q_data),
    .q_pop         (q_pop),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_data      (out_data)
  );

endmodule
`default_nettype wire
